[design/dsd_pkg.sv]
// ---------------------------------------------------------------------------
// dsd_pkg
// shared widths, codes and the result beat type of the dibit sync deframer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsd_pkg;

   localparam int unsigned DIBIT_W     = 2;
   localparam int unsigned SYNC_WORD_W = 40;
   localparam int unsigned POSITION_W  = 9;

   localparam logic [SYNC_WORD_W-1:0] SYNC_WORD_RESET = 40'hd4_71c9_634d;

   localparam logic SECTION_HEADER  = 1'b0;
   localparam logic SECTION_PAYLOAD = 1'b1;

   typedef struct packed {
      logic [DIBIT_W-1:0]    dibit;
      logic                  section;
      logic [POSITION_W-1:0] position;
      logic                  last;
   } result_type;

endpackage

[design/dibit_sync_deframer.sv]
// ---------------------------------------------------------------------------
// dibit_sync_deframer
// sync word search and header / payload tagging of a dibit stream
// ---------------------------------------------------------------------------
// One dibit is taken per beat, one beat every cycle. While searching, the
// dibit is shifted into a window of 2*SYNC_DIBITS bits that is compared with
// the low bits of the sync word register; searching gives no result. The
// dibit after a match opens the frame: HEADER_DIBITS header beats follow,
// then PAYLOAD_DIBITS payload beats, each with its position in the section
// and a last flag, then the search resumes with the window unchanged. The
// shift, compare and counter update are combinational before the result
// register, and a one-entry skid stage behind it keeps input flowing while a
// result waits; the input stalls only while that skid stage is occupied. The user
// writes the sync word through csr_wr_en / csr_wr_data only while idle (unchecked by the block).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dibit_sync_deframer #(
   parameter int unsigned HEADER_DIBITS  = 100,
   parameter int unsigned PAYLOAD_DIBITS = 360,
   parameter int unsigned SYNC_DIBITS    = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [dsd_pkg::SYNC_WORD_W-1:0]  csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dsd_pkg::DIBIT_W-1:0]      req_dibit,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dsd_pkg::DIBIT_W-1:0]      rsp_out_dibit,
   output logic                             rsp_section,
   output logic [dsd_pkg::POSITION_W-1:0]   rsp_position,
   output logic                             rsp_last
);

   import dsd_pkg::*;

   localparam int unsigned WIN_W = 2 * SYNC_DIBITS;
   localparam logic [POSITION_W-1:0] HEADER_END  = POSITION_W'(HEADER_DIBITS);
   localparam logic [POSITION_W-1:0] PAYLOAD_END = POSITION_W'(PAYLOAD_DIBITS);

   typedef enum logic [1:0] {
      MODE_SEARCH  = 2'd0,
      MODE_HEADER  = 2'd1,
      MODE_PAYLOAD = 2'd2
   } mode_type;

   mode_type                mode_ff, mode_in;
   logic [POSITION_W-1:0]   count_ff, count_in, count_inc;
   logic [WIN_W-1:0]        window_ff, window_in, window_shift;
   logic [WIN_W-1:0]        word_cmp;
   logic [SYNC_WORD_W-1:0]  sync_word_ff;

   result_type              result_in;
   logic                    result_gen;
   result_type              out_ff, skid_ff;
   logic                    out_valid_ff, skid_valid_ff;

   logic                    accept, take;

   // sync word bits above the window are ignored, window bits above the word compare to zero
   generate
      if (WIN_W > SYNC_WORD_W) begin : g_wide
         assign word_cmp = {{(WIN_W - SYNC_WORD_W){1'b0}}, sync_word_ff};
      end else begin : g_narrow
         assign word_cmp = sync_word_ff[WIN_W-1:0];
      end
   endgenerate

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;

   assign count_inc    = count_ff + 1'b1;
   assign window_shift = (window_ff << 2) | WIN_W'(req_dibit);

   always_comb begin
      mode_in            = mode_ff;
      count_in           = count_ff;
      window_in          = window_ff;
      result_gen         = 1'b0;
      result_in.dibit    = req_dibit;
      result_in.section  = SECTION_HEADER;
      result_in.position = count_ff;
      result_in.last     = 1'b0;
      case (mode_ff)
         MODE_HEADER: begin
            result_gen     = 1'b1;
            result_in.last = (count_inc == HEADER_END);
            count_in       = count_inc;
            if (count_inc == HEADER_END) begin
               count_in = '0;
               mode_in  = MODE_PAYLOAD;
            end
         end
         MODE_PAYLOAD: begin
            result_gen        = 1'b1;
            result_in.section = SECTION_PAYLOAD;
            result_in.last    = (count_inc == PAYLOAD_END);
            count_in          = count_inc;
            if (count_inc == PAYLOAD_END) begin
               count_in = '0;
               mode_in  = MODE_SEARCH;
            end
         end
         default: begin
            window_in = window_shift;
            if (window_shift == word_cmp) begin
               mode_in  = MODE_HEADER;
               count_in = '0;
            end else begin
               mode_in = MODE_SEARCH;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_SEARCH;
         count_ff      <= '0;
         window_ff     <= '0;
         sync_word_ff  <= SYNC_WORD_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sync_word_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff   <= mode_in;
            count_ff  <= count_in;
            window_ff <= window_in;
         end
         // result register with one skid entry behind it
         if (skid_valid_ff) begin
            if (take) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && result_gen) begin
            if (!out_valid_ff || take) begin
               out_ff       <= result_in;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result_in;
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_dibit = out_ff.dibit;
   assign rsp_section   = out_ff.section;
   assign rsp_position  = out_ff.position;
   assign rsp_last      = out_ff.last;

endmodule

[tb/dibit_sync_deframer_tb.sv]
// ---------------------------------------------------------------------------
// dibit_sync_deframer_tb
// self-checking bench for the sync word search and frame tagging
// ---------------------------------------------------------------------------
// A short table opens the run: the power-up sync word followed by the first
// header beats, with the results typed in. Random frames follow under several
// sync words: all zeros, all ones, a random word and the power-up word. Each
// frame has random content, and noise and damaged sync words are mixed in.
// Every accepted dibit goes through a local model of the deframer. Each
// result beat is checked field by field against the oldest predicted beat.
// Both sides idle and stall at random, and one phase runs without gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dibit_sync_deframer_tb;

   import dsd_pkg::*;

   localparam int unsigned HEADER_LEN    = 100;
   localparam int unsigned PAYLOAD_LEN   = 360;
   localparam int unsigned SYNC_LEN      = 20;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned WATCHDOG_MAX  = 1000;
   localparam int unsigned PRINT_MAX     = 100;

   typedef enum logic [1:0] {HUNT, IN_HEADER, IN_PAYLOAD} deframe_mode_type;
   typedef enum logic [1:0] {ROW_PREDICTED, ROW_QUIET, ROW_TYPED} row_kind_type;

   typedef struct packed {
      logic [DIBIT_W-1:0] dibit;
      row_kind_type       kind;
      result_type         want;
   } directed_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [SYNC_WORD_W-1:0] csr_wr_data = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [DIBIT_W-1:0]     req_dibit   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [DIBIT_W-1:0]     rsp_out_dibit;
   logic                   rsp_section;
   logic [POSITION_W-1:0]  rsp_position;
   logic                   rsp_last;

   // deframer model state
   logic [SYNC_WORD_W-1:0] sync_word_m;
   logic [2*SYNC_LEN-1:0]  window_m;
   deframe_mode_type       mode_m;
   logic [POSITION_W-1:0]  count_m;

   result_type  tagged_q[$];
   bit          calm         = 1'b0;
   int unsigned errors       = 0;
   int unsigned sent_beats   = 0;
   int unsigned header_beats = 0;
   int unsigned payload_beats = 0;
   int unsigned frames_done  = 0;
   int unsigned quiet_cycles = 0;

   directed_row_type directed_rows [25] = '{
      '{2'd2, ROW_PREDICTED, '0},
      '{2'd3, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0},
      '{2'd0, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0}, '{2'd3, ROW_QUIET, '0},
      '{2'd0, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0}, '{2'd3, ROW_QUIET, '0},
      '{2'd0, ROW_QUIET, '0}, '{2'd2, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0},
      '{2'd1, ROW_QUIET, '0}, '{2'd2, ROW_QUIET, '0}, '{2'd0, ROW_QUIET, '0},
      '{2'd3, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0}, '{2'd0, ROW_QUIET, '0},
      '{2'd3, ROW_QUIET, '0}, '{2'd1, ROW_QUIET, '0},
      '{2'd0, ROW_TYPED, '{2'd0, SECTION_HEADER, 9'd0, 1'b0}},
      '{2'd3, ROW_TYPED, '{2'd3, SECTION_HEADER, 9'd1, 1'b0}},
      '{2'd2, ROW_TYPED, '{2'd2, SECTION_HEADER, 9'd2, 1'b0}},
      '{2'd1, ROW_PREDICTED, '0}
   };

   dibit_sync_deframer #(
      .HEADER_DIBITS  (HEADER_LEN),
      .PAYLOAD_DIBITS (PAYLOAD_LEN),
      .SYNC_DIBITS    (SYNC_LEN)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_dibit     (req_dibit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_dibit (rsp_out_dibit),
      .rsp_section   (rsp_section),
      .rsp_position  (rsp_position),
      .rsp_last      (rsp_last)
   );

   always #4 clock = ~clock;

   task automatic reset_model();
      sync_word_m = SYNC_WORD_RESET;
      window_m    = '0;
      mode_m      = HUNT;
      count_m     = '0;
   endtask

   function automatic bit deframe_dibit(input logic [DIBIT_W-1:0] d, output result_type r);
      r = '0;
      case (mode_m)
         IN_HEADER: begin
            r.dibit    = d;
            r.section  = SECTION_HEADER;
            r.position = count_m;
            count_m    = count_m + 1'b1;
            r.last     = (count_m == POSITION_W'(HEADER_LEN));
            if (r.last) begin
               count_m = '0;
               mode_m  = IN_PAYLOAD;
            end
            return 1'b1;
         end
         IN_PAYLOAD: begin
            r.dibit    = d;
            r.section  = SECTION_PAYLOAD;
            r.position = count_m;
            count_m    = count_m + 1'b1;
            r.last     = (count_m == POSITION_W'(PAYLOAD_LEN));
            if (r.last) begin
               count_m = '0;
               mode_m  = HUNT;
            end
            return 1'b1;
         end
         default: begin
            window_m = {window_m[2*SYNC_LEN-3:0], d};
            if (window_m == sync_word_m[2*SYNC_LEN-1:0]) begin
               mode_m  = IN_HEADER;
               count_m = '0;
            end else begin
               mode_m = HUNT;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // one input beat: hold until taken, model it, then maybe leave a gap
   task automatic push_dibit(input logic [DIBIT_W-1:0] d, input row_kind_type kind,
                             input result_type typed);
      result_type r;
      bit         has;
      req_valid <= 1'b1;
      req_dibit <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_beats++;
      has = deframe_dibit(d, r);
      if (kind == ROW_TYPED) tagged_q.push_back(typed);
      else if (kind == ROW_PREDICTED && has) tagged_q.push_back(r);
      if (!calm && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         req_dibit <= DIBIT_W'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tagged_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_sync_word(input logic [SYNC_WORD_W-1:0] w);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sync_word_m = w;
   endtask

   task automatic run_phase(input int unsigned beats, input bit quiet, input int unsigned hold_at);
      logic [DIBIT_W-1:0] plan[$];
      int unsigned        k;
      int unsigned        j;
      int unsigned        pick;
      int unsigned        n;
      calm = quiet;
      for (k = 0; k < beats; k++) begin
         if (plan.size() == 0 && mode_m == HUNT) begin
            pick = $urandom_range(0, 99);
            n = (pick < 85) ? $urandom_range(0, 6) : $urandom_range(1, 30);
            for (j = 0; j < n; j++) plan.push_back(DIBIT_W'($urandom));
            if (pick < 85) begin
               for (j = SYNC_LEN; j > 0; j--) plan.push_back(sync_word_m[2*(j-1) +: 2]);
               if (pick >= 70) begin
                  j = n + $urandom_range(0, SYNC_LEN - 1);
                  plan[j] = plan[j] ^ DIBIT_W'($urandom_range(1, 3));
               end
            end
         end
         if (plan.size() != 0) push_dibit(plan.pop_front(), ROW_PREDICTED, '0);
         else push_dibit(DIBIT_W'($urandom), ROW_PREDICTED, '0);
         if (k == hold_at) settle();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tagged_q.size() == 0) begin
            flag_mismatch($sformatf("result beat pos %0d with nothing pending", rsp_position));
         end else begin
            want = tagged_q.pop_front();
            if (rsp_out_dibit !== want.dibit)
               flag_mismatch($sformatf("dibit got %0d want %0d at pos %0d",
                                       rsp_out_dibit, want.dibit, want.position));
            if (rsp_section !== want.section)
               flag_mismatch($sformatf("section got %0d want %0d at pos %0d",
                                       rsp_section, want.section, want.position));
            if (rsp_position !== want.position)
               flag_mismatch($sformatf("position got %0d want %0d",
                                       rsp_position, want.position));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last got %0d want %0d at pos %0d",
                                       rsp_last, want.last, want.position));
         end
         if (rsp_section === SECTION_HEADER) header_beats++;
         else payload_beats++;
         if (rsp_section === SECTION_PAYLOAD && rsp_last === 1'b1) frames_done++;
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < 32);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: %0d cycles without a beat, %0d results pending",
                  quiet_cycles, tagged_q.size());
         $display("dibit_sync_deframer_tb: errors");
         $finish;
      end
   end

   initial begin
      int unsigned i;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < 25; i++)
         push_dibit(directed_rows[i].dibit, directed_rows[i].kind, directed_rows[i].want);
      run_phase(450, 1'b0, 32'hffff_ffff);
      load_sync_word('0);
      run_phase(400, 1'b0, 32'hffff_ffff);
      load_sync_word('1);
      run_phase(400, 1'b1, 32'hffff_ffff);
      load_sync_word({8'($urandom), 32'($urandom)});
      run_phase(400, 1'b0, 200);
      load_sync_word(SYNC_WORD_RESET);
      run_phase(300, 1'b0, 32'hffff_ffff);
      settle();
      $display("covered %0d input beats, %0d header and %0d payload beats, %0d whole frames",
               sent_beats, header_beats, payload_beats, frames_done);
      $display("sync words: power-up, all zeros, all ones, random; damaged syncs and noise");
      if (errors == 0) begin
         $display("dibit_sync_deframer_tb: clean");
      end else begin
         $display("dibit_sync_deframer_tb: errors");
      end
      $finish;
   end

endmodule

[sim.f]
design/dsd_pkg.sv
design/dibit_sync_deframer.sv
tb/dibit_sync_deframer_tb.sv
